@@ hw/rtl/svc_pkg.sv @@
package svc_pkg;

    localparam int unsigned ValueW = 32;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CntW   = 3;
    localparam int unsigned QDepth = 2;
    localparam int unsigned QPtrW  = 1;
    localparam int unsigned QCntW  = 2;

    // direction register codes
    localparam logic DirEncode = 1'b0;
    localparam logic DirDecode = 1'b1;

    // byte positions within an encoded value
    localparam logic [CntW-1:0] Pos0 = 3'd0;
    localparam logic [CntW-1:0] Pos1 = 3'd1;
    localparam logic [CntW-1:0] Pos2 = 3'd2;
    localparam logic [CntW-1:0] Pos3 = 3'd3;
    localparam logic [CntW-1:0] Pos4 = 3'd4;

    // one classified job waiting for the back end
    typedef struct packed {
        logic              is_dec;  // decode result (one word) vs encode run
        logic [ValueW-1:0] word;    // encode: magnitude, decode: final value
        logic              sign;    // encode sign bit
        logic [CntW-1:0]   nbytes;  // encode byte count, 1..5
        logic              trunc;   // decode cut off by buffer end
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic full;
        logic head_valid;
    } t_q_stat;

endpackage

@@ hw/rtl/svc_front.sv @@
module svc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_accept,
    input  logic signed [svc_pkg::ValueW-1:0] i_value_in,
    input  logic [svc_pkg::ByteW-1:0]     i_byte_in,
    input  logic                          i_buffer_end,
    output svc_pkg::t_push                o_push
);

    logic                        r_dir;
    logic [svc_pkg::ValueW-1:0]  r_acc, n_acc;
    logic [svc_pkg::CntW-1:0]    r_idx, n_idx;
    logic                        r_sign, n_sign;

    logic [svc_pkg::ValueW-1:0]  w_acc;
    logic                        w_sign;
    logic                        w_done;
    logic [svc_pkg::ValueW-1:0]  w_mag;
    logic                        w_neg;
    logic [svc_pkg::CntW-1:0]    w_nbytes;

    // encode classification: magnitude word and byte count
    always_comb begin
        w_neg = i_value_in[svc_pkg::ValueW-1];
        w_mag = w_neg ? ~i_value_in : i_value_in;
        if (w_mag[31:6] == '0)       w_nbytes = 3'd1;
        else if (w_mag[31:13] == '0) w_nbytes = 3'd2;
        else if (w_mag[31:20] == '0) w_nbytes = 3'd3;
        else if (w_mag[31:27] == '0) w_nbytes = 3'd4;
        else                         w_nbytes = 3'd5;
    end

    // decode: merge this byte into the accumulator
    always_comb begin
        w_acc  = r_acc;
        w_sign = r_sign;
        case (r_idx)
            svc_pkg::Pos0: begin
                w_sign = i_byte_in[6];
                w_acc  = {26'd0, i_byte_in[5:0]};
            end
            svc_pkg::Pos1: w_acc[12:6]  = i_byte_in[6:0];
            svc_pkg::Pos2: w_acc[19:13] = i_byte_in[6:0];
            svc_pkg::Pos3: w_acc[26:20] = i_byte_in[6:0];
            svc_pkg::Pos4: w_acc[31:27] = i_byte_in[4:0];  // upper bits dropped
            default: w_acc = r_acc;
        endcase
        w_done = !i_byte_in[7] || (r_idx >= svc_pkg::Pos4);
    end

    // next decode state and queue push
    always_comb begin
        n_acc  = r_acc;
        n_idx  = r_idx;
        n_sign = r_sign;
        o_push = '0;
        if (i_accept) begin
            if (r_dir == svc_pkg::DirEncode) begin
                o_push.valid        = 1'b1;
                o_push.entry.is_dec = 1'b0;
                o_push.entry.word   = w_mag;
                o_push.entry.sign   = w_neg;
                o_push.entry.nbytes = w_nbytes;
                o_push.entry.trunc  = 1'b0;
            end else if (!w_done && !i_buffer_end) begin
                n_acc  = w_acc;
                n_sign = w_sign;
                n_idx  = r_idx + 3'd1;
            end else begin
                o_push.valid        = 1'b1;
                o_push.entry.is_dec = 1'b1;
                o_push.entry.word   = w_sign ? ~w_acc : w_acc;
                o_push.entry.sign   = 1'b0;
                o_push.entry.nbytes = 3'd1;
                o_push.entry.trunc  = !w_done;
                n_acc  = '0;
                n_sign = 1'b0;
                n_idx  = '0;
            end
        end
        if (i_cfg_we) begin
            n_acc  = '0;
            n_sign = 1'b0;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= svc_pkg::DirEncode;
            r_acc  <= '0;
            r_idx  <= '0;
            r_sign <= 1'b0;
        end else begin
            if (i_cfg_we) r_dir <= i_cfg_wdata;
            r_acc  <= n_acc;
            r_idx  <= n_idx;
            r_sign <= n_sign;
        end
    end

endmodule

@@ hw/rtl/svc_queue.sv @@
module svc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  svc_pkg::t_push    i_push,
    input  logic              i_pop,
    output svc_pkg::t_q_stat  o_stat,
    output svc_pkg::t_entry   o_head
);

    svc_pkg::t_entry               r_mem [svc_pkg::QDepth];
    logic [svc_pkg::QPtrW-1:0]     r_wp, r_rp;
    logic [svc_pkg::QCntW-1:0]     r_count, n_count;

    assign o_stat.full       = (r_count == 2'(svc_pkg::QDepth));
    assign o_stat.head_valid = (r_count != '0);
    assign o_head            = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) n_count = r_count + 2'd1;
        if (!i_push.valid && i_pop) n_count = r_count - 2'd1;
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) r_mem[r_wp] <= i_push.entry;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) r_wp <= r_wp + 1'b1;
            if (i_pop)        r_rp <= r_rp + 1'b1;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (!o_stat.full || i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_stat.head_valid)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(svc_pkg::QDepth))
        else $error("queue count out of range");

endmodule

@@ hw/rtl/svc_back.sv @@
module svc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  svc_pkg::t_q_stat              i_stat,
    input  svc_pkg::t_entry               i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [svc_pkg::ByteW-1:0]     o_byte_out,
    output logic signed [svc_pkg::ValueW-1:0] o_value_out,
    output logic                          o_last_of_run,
    output logic                          o_truncated
);

    logic [svc_pkg::CntW-1:0]    r_bidx, n_bidx;
    logic                        r_ov;
    logic [svc_pkg::ByteW-1:0]   r_byte;
    logic [svc_pkg::ValueW-1:0]  r_val;
    logic                        r_last;
    logic                        r_trunc;

    logic                        w_load;
    logic                        w_last;
    logic [6:0]                  w_bits;
    logic [svc_pkg::ByteW-1:0]   w_byte;

    // current byte of the head encode run
    always_comb begin
        case (r_bidx)
            svc_pkg::Pos0: w_bits = {i_head.sign, i_head.word[5:0]};
            svc_pkg::Pos1: w_bits = i_head.word[12:6];
            svc_pkg::Pos2: w_bits = i_head.word[19:13];
            svc_pkg::Pos3: w_bits = i_head.word[26:20];
            svc_pkg::Pos4: w_bits = {2'b00, i_head.word[31:27]};
            default:       w_bits = '0;
        endcase
        w_last = i_head.is_dec || (r_bidx == i_head.nbytes - 3'd1);
        w_byte = i_head.is_dec ? '0 : {!w_last, w_bits};
    end

    assign w_load = i_stat.head_valid && (!r_ov || i_ready);
    assign o_pop  = w_load && w_last;

    always_comb begin
        n_bidx = r_bidx;
        if (w_load) n_bidx = w_last ? '0 : r_bidx + 3'd1;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_bidx <= '0;
        end else begin
            r_bidx <= n_bidx;
            if (w_load)       r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte  <= w_byte;
            r_val   <= i_head.is_dec ? i_head.word : '0;
            r_last  <= w_last;
            r_trunc <= i_head.is_dec && i_head.trunc;
        end
    end

    assign o_valid       = r_ov;
    assign o_byte_out    = r_byte;
    assign o_value_out   = r_val;
    assign o_last_of_run = r_last;
    assign o_truncated   = r_trunc;

    a_run_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bidx != '0) |-> (i_stat.head_valid && !i_head.is_dec))
        else $error("encode run in progress without its queue entry");

    a_more_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_last) |-> i_stat.head_valid)
        else $error("non-final byte shown but run is gone");

endmodule

@@ hw/rtl/signed_varint_stream_codec_core.sv @@
// Signed varint codec, 6/7-bit groups with one's-complement sign.
// Input channel (i_valid / o_ready): in encode mode each word carries an
// integer on i_value_in; in decode mode each word carries one encoded byte on
// i_byte_in, with i_buffer_end marking the last byte of a buffer.
// Output channel (o_valid / i_ready): encode yields 1 to 5 byte words per
// integer, o_last_of_run on the last; decode yields one value word per
// completed (or cut-off, o_truncated) value.
// i_cfg_we / i_cfg_wdata set the direction (0 encode, 1 decode) and clear the
// partial decode value; write only while the block is idle.
// An accepted input word is written into the job queue, then into the output
// register. Throughput: one input word per cycle in decode mode while the
// queue is not full; in encode mode one output byte per cycle while the
// receiver is ready, set by the single output byte register fed from a
// two-entry job queue between the front classifier and the back serializer.
// Reset: direction goes to encode, decode state and queue are cleared.
// When the receiver stalls, the output word holds, the queue fills, and
// o_ready drops once both queue entries are taken.
module signed_varint_stream_codec_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [svc_pkg::ValueW-1:0] i_value_in,
    input  logic [svc_pkg::ByteW-1:0]     i_byte_in,
    input  logic                          i_buffer_end,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [svc_pkg::ByteW-1:0]     o_byte_out,
    output logic signed [svc_pkg::ValueW-1:0] o_value_out,
    output logic                          o_last_of_run,
    output logic                          o_truncated
);

    svc_pkg::t_push    w_push;
    svc_pkg::t_q_stat  w_stat;
    svc_pkg::t_entry   w_head;
    logic              w_pop;
    logic              w_accept;

    assign o_ready  = !w_stat.full;
    assign w_accept = i_valid && o_ready;

    svc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (w_accept),
        .i_value_in   (i_value_in),
        .i_byte_in    (i_byte_in),
        .i_buffer_end (i_buffer_end),
        .o_push       (w_push)
    );

    svc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_stat  (w_stat),
        .o_head  (w_head)
    );

    svc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stat        (w_stat),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_byte_out    (o_byte_out),
        .o_value_out   (o_value_out),
        .o_last_of_run (o_last_of_run),
        .o_truncated   (o_truncated)
    );

endmodule
